### hw/rtl/bso_pkg.sv
// Shared types and constants for the broadcast source offset pipeline.
// No dependencies.
package bso_pkg;

   localparam int unsigned EXT_W      = 16;
   localparam int unsigned FLAT_W     = 31;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned ACC_W      = 33;
   localparam int unsigned PROD_W     = ACC_W + EXT_W;
   localparam int unsigned DIV_STEPS  = 4;
   localparam int unsigned DIV_STAGES = WORD_W / DIV_STEPS;

   localparam logic [ACC_W-1:0] ACC_CAP = {1'b1, {(ACC_W-1){1'b0}}};

   // Item state carried down the pipeline: dividend/quotient word,
   // partial remainder, running offset and running stride.
   typedef struct packed {
      logic [WORD_W-1:0] w;
      logic [EXT_W-1:0]  r;
      logic [ACC_W-1:0]  offset;
      logic [ACC_W-1:0]  stride;
   } item_type;

endpackage

### hw/rtl/broadcast_source_offset.sv
// Broadcast source offset generator: maps a flat index of a broadcast output
// tensor to the flat offset in the row-major input tensor. One transaction is
// accepted per cycle unless the output stalls, and results leave in order;
// each dimension spends eight stages in a pipelined restoring divider (four
// quotient bits per stage), one in the weight multipliers and one in the
// saturating accumulator. The whole pipeline holds while a result waits at
// the output register, so throughput is one per cycle whenever rsp_ready is
// high. Extents are written through the csr_ port (indices 0..MAX_DIMS-1 for
// output extents, then input extents, outermost first) while no transaction
// is in flight (the user's duty, unenforced); writes beyond the list are
// dropped. An offset above 2^31-1 gives src_offset zero with overflow set.
module broadcast_source_offset #(
   parameter int unsigned MAX_DIMS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [bso_pkg::FLAT_W-1:0]           req_out_flat,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [bso_pkg::FLAT_W-1:0]           rsp_src_offset,
   output logic                                 rsp_overflow,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [$clog2(2*MAX_DIMS):0]          csr_index,
   input  logic [bso_pkg::EXT_W-1:0]            csr_wdata
);
   import bso_pkg::*;

   localparam int unsigned IDX_W = $clog2(2*MAX_DIMS) + 1;

   logic [EXT_W-1:0] out_ext_ff [MAX_DIMS];
   logic [EXT_W-1:0] in_ext_ff  [MAX_DIMS];
   logic             adv;

   assign csr_ready = 1'b1;

   // Extent registers: decode the index against each register's place
   for (genvar g = 0; g < MAX_DIMS; g++) begin : g_cfg
      always_ff @(posedge clock) begin
         if (reset) begin
            out_ext_ff[g] <= EXT_W'(1);
            in_ext_ff[g]  <= EXT_W'(1);
         end else if (csr_valid) begin
            if (csr_index == IDX_W'(g)) begin
               out_ext_ff[g] <= csr_wdata;
            end
            if (csr_index == IDX_W'(MAX_DIMS + g)) begin
               in_ext_ff[g] <= csr_wdata;
            end
         end
      end
   end

   // Advance every stage unless a result waits untaken
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   logic     v  [MAX_DIMS+1];
   item_type it [MAX_DIMS+1];

   assign v[0]  = req_valid;
   assign it[0] = '{w: {1'b0, req_out_flat}, r: '0, offset: '0, stride: ACC_W'(1)};

   // Innermost dimension first; each quotient feeds the next dimension
   for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
      bso_dim u_dim (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .out_ext   (out_ext_ff[MAX_DIMS-1-k]),
         .in_ext    (in_ext_ff[MAX_DIMS-1-k]),
         .in_valid  (v[k]),
         .in_item   (it[k]),
         .out_valid (v[k+1]),
         .out_item  (it[k+1])
      );
   end

   // The last accumulator register is the output register
   assign rsp_valid      = v[MAX_DIMS];
   assign rsp_overflow   = (it[MAX_DIMS].offset[ACC_W-1:FLAT_W] != '0);
   assign rsp_src_offset = rsp_overflow ? '0 : it[MAX_DIMS].offset[FLAT_W-1:0];

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_src_offset == '0)
      else $error("overflow with non-zero offset");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");
endmodule

### hw/rtl/bso_div_stage.sv
// One register stage of the restoring divider: DIV_STEPS quotient bits.
// Depends on bso_pkg.
module bso_div_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic [bso_pkg::EXT_W-1:0] divisor,
   input  logic                     in_valid,
   input  bso_pkg::item_type        in_item,
   output logic                     out_valid,
   output bso_pkg::item_type        out_item
);
   import bso_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   always_comb begin
      logic [EXT_W:0] rr;
      logic           q;
      item_in = in_item;
      for (int s = 0; s < DIV_STEPS; s++) begin
         rr = {item_in.r, item_in.w[WORD_W-1]};
         q  = (rr >= {1'b0, divisor});
         if (q) begin
            rr = rr - {1'b0, divisor};
         end
         item_in.r = rr[EXT_W-1:0];
         item_in.w = {item_in.w[WORD_W-2:0], q};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

### hw/rtl/bso_dim.sv
// One dimension: divider stages, then weight multiply, then saturating add.
// Depends on bso_pkg and bso_div_stage.
module bso_dim (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic [bso_pkg::EXT_W-1:0] out_ext,
   input  logic [bso_pkg::EXT_W-1:0] in_ext,
   input  logic                     in_valid,
   input  bso_pkg::item_type        in_item,
   output logic                     out_valid,
   output bso_pkg::item_type        out_item
);
   import bso_pkg::*;

   logic [EXT_W-1:0] oe;
   logic [EXT_W-1:0] ie;
   logic             bcast;
   logic             v [DIV_STAGES+1];
   item_type         it [DIV_STAGES+1];

   // A zero extent behaves as extent one.
   assign oe    = (out_ext == '0) ? EXT_W'(1) : out_ext;
   assign ie    = (in_ext == '0) ? EXT_W'(1) : in_ext;
   assign bcast = (ie == EXT_W'(1));

   assign v[0]  = in_valid;
   assign it[0] = '{w: in_item.w, r: '0, offset: in_item.offset, stride: in_item.stride};

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      bso_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .divisor   (oe),
         .in_valid  (v[g]),
         .in_item   (it[g]),
         .out_valid (v[g+1]),
         .out_item  (it[g+1])
      );
   end

   // Multiply stage
   logic              mul_valid_ff;
   item_type          mul_item_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] sprod_ff;
   logic [EXT_W-1:0]  coord;

   assign coord = bcast ? '0 : it[DIV_STAGES].r;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (adv) begin
         mul_valid_ff <= v[DIV_STAGES];
      end
      if (adv) begin
         mul_item_ff <= it[DIV_STAGES];
         prod_ff     <= it[DIV_STAGES].stride * coord;
         sprod_ff    <= it[DIV_STAGES].stride * ie;
      end
   end

   // Accumulate stage, saturating at ACC_CAP
   logic             acc_valid_ff;
   item_type         acc_item_ff;
   item_type         acc_item_in;
   logic [ACC_W-1:0] prod_sat;
   logic [ACC_W:0]   sum;

   always_comb begin
      prod_sat    = (prod_ff > PROD_W'(ACC_CAP)) ? ACC_CAP : prod_ff[ACC_W-1:0];
      sum         = {1'b0, mul_item_ff.offset} + {1'b0, prod_sat};
      acc_item_in = mul_item_ff;
      acc_item_in.offset = (sum > {1'b0, ACC_CAP}) ? ACC_CAP : sum[ACC_W-1:0];
      acc_item_in.stride = (sprod_ff > PROD_W'(ACC_CAP)) ? ACC_CAP
                                                         : sprod_ff[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
      end else if (adv) begin
         acc_valid_ff <= mul_valid_ff;
      end
      if (adv) begin
         acc_item_ff <= acc_item_in;
      end
   end

   assign out_valid = acc_valid_ff;
   assign out_item  = acc_item_ff;
endmodule

### verif/tb_broadcast_source_offset.sv
`timescale 1ns / 1ps
// Testbench for broadcast_source_offset: drives flat indices under directed
// and random shapes and checks each result against an in-bench predictor.
// Depends on bso_pkg and the broadcast_source_offset RTL.

class offset_scoreboard;
   logic [15:0] out_ext[4];
   logic [15:0] in_ext[4];
   logic [31:0] want_offset[$];
   logic        want_ovf[$];
   int          errors;

   function new();
      errors = 0;
      for (int i = 0; i < 4; i++) begin
         out_ext[i] = 1;
         in_ext[i]  = 1;
      end
   endfunction

   function void set_extent(int idx, logic [15:0] v);
      if (idx < 4) out_ext[idx] = v;
      else if (idx < 8) in_ext[idx-4] = v;
   endfunction

   // work out the source offset for one flat index
   function void note_index(logic [30:0] flat);
      logic [31:0] rem;
      logic [63:0] offs, stride;
      logic [31:0] oe, ie, coord;
      rem = {1'b0, flat};
      offs = 0;
      stride = 1;
      for (int i = 3; i >= 0; i--) begin
         oe = (out_ext[i] == 0) ? 1 : out_ext[i];
         ie = (in_ext[i] == 0) ? 1 : in_ext[i];
         coord = rem % oe;
         rem = rem / oe;
         if (ie != 1) offs += stride * coord;
         if (offs > 64'h1_0000_0000) offs = 64'h1_0000_0000;
         stride *= ie;
         if (stride > 64'h1_0000_0000) stride = 64'h1_0000_0000;
      end
      if (offs > 64'h7FFF_FFFF) begin
         want_offset.push_back(0);
         want_ovf.push_back(1);
      end else begin
         want_offset.push_back(offs[31:0]);
         want_ovf.push_back(0);
      end
   endfunction

   function void check_result(logic [30:0] offs, logic ovf);
      logic [31:0] e;
      logic        eo;
      if (want_offset.size() == 0) begin
         $error("result with nothing expected: src_offset %0d", offs);
         errors++;
         return;
      end
      e = want_offset.pop_front();
      eo = want_ovf.pop_front();
      if (offs !== e[30:0]) begin
         $error("src_offset expected %0d actual %0d", e[30:0], offs);
         errors++;
      end
      if (ovf !== eo) begin
         $error("overflow expected %0d actual %0d", eo, ovf);
         errors++;
      end
   endfunction
endclass

module tb_broadcast_source_offset;
   import bso_pkg::*;

   localparam int DIMS = 4;
   localparam int IDX_W = $clog2(2*DIMS) + 1;
   localparam int N_RANDOM = 930;
   localparam int DRAIN_CYCLES = 10 * DIMS + 20;

   // register indexes: output extents first, then input extents
   localparam int REG_OUT_D0 = 0;
   localparam int REG_IN_D0  = DIMS;
   localparam int N_REGS     = 2 * DIMS;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [FLAT_W-1:0] req_out_flat = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [FLAT_W-1:0] rsp_src_offset;
   logic rsp_overflow;
   logic csr_valid = 0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [EXT_W-1:0] csr_wdata = '0;

   offset_scoreboard offsets = new();
   int burst_left = 0;

   broadcast_source_offset #(.MAX_DIMS(DIMS)) dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // hard stop: reports TB_ERROR and ends a run that never finishes
   initial begin
      #(8 * 2000000);
      $display("TB_ERROR");
      $finish;
   end

   // receiver: stall on a pattern of its own, with calm stretches
   always @(posedge clock) begin
      int phase;
      phase = int'(($time / 8) % 600);
      if (reset) rsp_ready <= 0;
      else if (phase < 150) rsp_ready <= 1;
      else if (phase < 400) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= ($urandom_range(0, 2) == 0);
      if (!reset && rsp_valid && rsp_ready)
         offsets.check_result(rsp_src_offset, rsp_overflow);
   end

   // write one extent register; block is idle when called.
   // Valid stays high so that writes follow back to back; the caller drops it.
   task automatic write_extent(int idx, logic [15:0] v);
      csr_valid <= 1;
      csr_index <= IDX_W'(idx);
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      offsets.set_extent(idx, v);
   endtask

   // send one index, honouring burst/gap pacing; valid drops only for a gap
   task automatic send_index(logic [30:0] flat);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1;
      req_out_flat <= flat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      offsets.note_index(flat);
   endtask

   // hold until every expected result has come, then let the pipe settle
   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 0;
      while (offsets.want_offset.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_extent();
      case ($urandom_range(0, 5))
         0: return 16'd1;
         1: return 16'd0;
         2: return 16'hFFFF;
         default: return 16'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic logic [30:0] pick_flat();
      case ($urandom_range(0, 4))
         0: return 31'($urandom_range(0, 255));
         1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 255));
         default: return 31'($urandom());
      endcase
   endfunction

   initial begin
      logic [15:0] shape_a[8];
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset shape maps everything to zero
      send_index(0);
      send_index(31'h7FFF_FFFF);
      drain();

      // largest extents everywhere: each offset equals its flat index, no overflow
      for (int i = 0; i < N_REGS; i++) write_extent(i, 16'hFFFF);
      csr_valid <= 0;
      send_index(31'h7FFF_FFFF);
      send_index(31'h0001_0000);
      send_index(0);
      send_index(31'h5555_5555);
      drain();

      // zero extent counts as one; out-of-range index is dropped
      for (int i = 0; i < N_REGS; i++) write_extent(i, 0);
      write_extent(N_REGS, 16'h0007);
      write_extent(N_REGS + 3, 16'h1234);
      csr_valid <= 0;
      send_index(31'h2AAA_AAAA);
      send_index(12345);
      drain();

      // broadcast inner and outermost dims, incompatible second dim, leftover quotient
      shape_a = '{3, 4, 5, 6, 1, 2, 5, 1};
      for (int i = 0; i < N_REGS; i++) write_extent(i, shape_a[i]);
      csr_valid <= 0;
      for (int k = 0; k < 12; k++) send_index(31'(k * 37));
      send_index(31'h7FFF_FFFF);
      drain();

      // random phases with fresh shapes, sender pausing to drain each time
      for (int ph = 0; ph < 10; ph++) begin
         for (int i = 0; i < N_REGS; i++) write_extent(i, pick_extent());
         csr_valid <= 0;
         for (int k = 0; k < N_RANDOM / 10; k++) send_index(pick_flat());
         drain();
      end

      if (offsets.errors == 0 && offsets.want_offset.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

### broadcast_source_offset.f
hw/rtl/bso_pkg.sv
hw/rtl/bso_div_stage.sv
hw/rtl/bso_dim.sv
hw/rtl/broadcast_source_offset.sv
verif/tb_broadcast_source_offset.sv
